// ===== src/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared widths, byte codes, status codes and the hex digit decoder for the
// chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   // input word action codes
   localparam logic ACT_DATA = 1'b0;
   localparam logic ACT_END  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

   // framing bytes
   localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] BYTE_TAB   = 8'h09;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   // ASCII hex digit decode (0-9, a-f, A-F)
   function automatic hex_digit_type hex_decode(input logic [BYTE_W-1:0] b);
      hex_digit_type d;
      d.is_hex = 1'b0;
      d.value  = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         d.is_hex = 1'b1;
         d.value  = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d.is_hex = 1'b1;
         d.value  = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d.is_hex = 1'b1;
         d.value  = 4'(b - 8'h37);
      end
      return d;
   endfunction

endpackage

// ===== src/cbd_if.sv =====
// ----------------------------------------------------------------------------
// cbd_if
// Valid/ready channel interfaces for the chunked body decoder: one for body
// input words and one for decoded result words.
// ----------------------------------------------------------------------------
interface cbd_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [cbd_pkg::BYTE_W-1:0]  data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

interface cbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          payload_valid;
   logic [cbd_pkg::BYTE_W-1:0]    payload_byte;
   logic [cbd_pkg::STATUS_W-1:0]  status;

   modport source (output valid, payload_valid, payload_byte, status, input ready);
   modport sink   (input valid, payload_valid, payload_byte, status, output ready);
endinterface

// ===== src/chunked_body_decoder.sv =====
// Result: an accepted input word's result word is in the output register in the
//   cycle after the word is taken.
// Throughput: 1 word per cycle while the result is not stalled; the decode step
//   and the chunk counter update are both combinational, and the output register
//   lets a new word in while a result is being taken.
// Reset: synchronous, active high; returns to the start of a size line with
//   an empty output register.
// ----------------------------------------------------------------------------
// chunked_body_decoder
// Streaming HTTP chunked body decoder, one byte per word. Parses size lines,
// passes chunk data through and checks CR LF framing; errors are sticky.
// ----------------------------------------------------------------------------
module chunked_body_decoder #(
   parameter int SIZE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   cbd_req_if.sink   req_chan,
   cbd_rsp_if.source rsp_chan
);

   // phase codes
   localparam logic [2:0] PH_SIZE = 3'd0;
   localparam logic [2:0] PH_DATA = 3'd1;
   localparam logic [2:0] PH_DCR  = 3'd2;
   localparam logic [2:0] PH_DLF  = 3'd3;
   localparam logic [2:0] PH_ZCR  = 3'd4;
   localparam logic [2:0] PH_ZLF  = 3'd5;
   localparam logic [2:0] PH_DONE = 3'd6;
   localparam logic [2:0] PH_ERR  = 3'd7;

   logic [2:0]           phase_ff, phase_in;
   logic [SIZE_BITS-1:0] chunk_rem_ff, chunk_rem_in;
   logic [SIZE_BITS-1:0] size_value_ff, size_value_in;
   logic                 line_text_ff, line_text_in;
   logic                 digits_open_ff, digits_open_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_pvalid_ff, out_pvalid_in;
   logic [cbd_pkg::BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic [cbd_pkg::STATUS_W-1:0] out_status_ff, out_status_in;

   logic                   accept;
   logic [cbd_pkg::BYTE_W-1:0] b;
   cbd_pkg::hex_digit_type hex;
   logic                   is_blank;
   logic [SIZE_BITS-1:0]   chunk_dec;

   // take a word whenever the output register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign b         = req_chan.data_byte;
   assign hex       = cbd_pkg::hex_decode(b);
   assign is_blank  = (b == cbd_pkg::BYTE_SPACE) || (b == cbd_pkg::BYTE_TAB) ||
                      (b == cbd_pkg::BYTE_CR);
   assign chunk_dec = chunk_rem_ff - SIZE_BITS'(1);

   // decode step for one word
   always_comb begin
      phase_in       = phase_ff;
      chunk_rem_in   = chunk_rem_ff;
      size_value_in  = size_value_ff;
      line_text_in   = line_text_ff;
      digits_open_in = digits_open_ff;
      out_pvalid_in  = 1'b0;
      out_byte_in    = '0;

      if (req_chan.action == cbd_pkg::ACT_END) begin
         if (phase_ff != PH_DONE) begin
            phase_in = PH_ERR;
         end
      end else begin
         unique case (phase_ff)
            PH_SIZE: begin
               if (b == cbd_pkg::BYTE_LF) begin
                  // end of size line: pick the next phase, start a new line
                  if (line_text_ff) begin
                     if (size_value_ff == '0) begin
                        phase_in = PH_ZCR;
                     end else begin
                        chunk_rem_in = size_value_ff;
                        phase_in     = PH_DATA;
                     end
                  end
                  size_value_in  = '0;
                  line_text_in   = 1'b0;
                  digits_open_in = 1'b1;
               end else if (!(line_text_ff == 1'b0 && is_blank)) begin
                  line_text_in = 1'b1;
                  if (digits_open_ff && hex.is_hex) begin
                     // next digit would overflow the size field
                     if (size_value_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                        phase_in = PH_ERR;
                     end else begin
                        size_value_in = {size_value_ff[SIZE_BITS-5:0], hex.value};
                     end
                  end else begin
                     digits_open_in = 1'b0;
                  end
               end
            end
            PH_DATA: begin
               out_pvalid_in = 1'b1;
               out_byte_in   = b;
               chunk_rem_in  = chunk_dec;
               if (chunk_dec == '0) begin
                  phase_in = PH_DCR;
               end
            end
            PH_DCR: begin
               phase_in = (b == cbd_pkg::BYTE_CR) ? PH_DLF : PH_ERR;
            end
            PH_DLF: begin
               if (b == cbd_pkg::BYTE_LF) begin
                  phase_in       = PH_SIZE;
                  size_value_in  = '0;
                  line_text_in   = 1'b0;
                  digits_open_in = 1'b1;
               end else begin
                  phase_in = PH_ERR;
               end
            end
            PH_ZCR: begin
               phase_in = (b == cbd_pkg::BYTE_CR) ? PH_ZLF : PH_ERR;
            end
            PH_ZLF: begin
               phase_in = (b == cbd_pkg::BYTE_LF) ? PH_DONE : PH_ERR;
            end
            PH_DONE, PH_ERR: begin
            end
            default: begin
            end
         endcase
      end

      // status after this word
      if (phase_in == PH_DONE) begin
         out_status_in = cbd_pkg::ST_DONE;
      end else if (phase_in == PH_ERR) begin
         out_status_in = cbd_pkg::ST_ERROR;
      end else begin
         out_status_in = cbd_pkg::ST_BUSY;
      end
   end

   // output register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SIZE;
         chunk_rem_ff   <= '0;
         size_value_ff  <= '0;
         line_text_ff   <= 1'b0;
         digits_open_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff       <= phase_in;
            chunk_rem_ff   <= chunk_rem_in;
            size_value_ff  <= size_value_in;
            line_text_ff   <= line_text_in;
            digits_open_ff <= digits_open_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         out_pvalid_ff <= out_pvalid_in;
         out_byte_ff   <= out_byte_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.payload_valid = out_pvalid_ff;
   assign rsp_chan.payload_byte  = out_byte_ff;
   assign rsp_chan.status        = out_status_ff;

endmodule

// ===== src/cbd_checker.sv =====
// ----------------------------------------------------------------------------
// cbd_checker
// Port-level checks for the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cbd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_payload_valid,
   input logic [cbd_pkg::BYTE_W-1:0]   rsp_payload_byte,
   input logic [cbd_pkg::STATUS_W-1:0] rsp_status
);

   // a stalled result blocks new input words
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted while result stalled");

   // every accepted input word has a result word on the next cycle
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted word without a result");

   // payload bytes only appear while decoding is in progress
   a_payload_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload_valid) |-> (rsp_status == cbd_pkg::ST_BUSY))
      else $error("payload byte with done or error status");

   // no payload means a zero byte
   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload_valid) |-> (rsp_payload_byte == '0))
      else $error("nonzero byte without payload");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
                                     $stable(rsp_payload_byte)))
      else $error("stalled result changed");

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_payload_valid (rsp_chan.payload_valid),
   .rsp_payload_byte  (rsp_chan.payload_byte),
   .rsp_status        (rsp_chan.status)
);
